// ===== rtl/core/pic_particle_push_core_assert.svh =====
// Assertion macros used by the checker of the particle push core.
`ifndef PIC_PARTICLE_PUSH_CORE_ASSERT_SVH
`define PIC_PARTICLE_PUSH_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PPP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PPP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/ppp_pkg.sv =====
// Shared types, constants and helper functions of the particle push core.
package ppp_pkg;

  localparam int MESH_CELLS_DEF = 128;
  localparam int CFG_IDX_W      = 3;
  localparam int MUL_W          = 33;
  localparam int PROD_W         = 2 * MUL_W;

  localparam logic [47:0] MAX48   = 48'hFFFF_FFFF_FFFF;
  localparam logic [16:0] ONE_Q16 = 17'h1_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PUSH_GAIN = 3'd0,
    REG_ROT_COS   = 3'd1,
    REG_ROT_SIN   = 3'd2,
    REG_INV_CELL  = 3'd3,
    REG_HALF_MASS = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic signed [31:0] push_gain;
    logic signed [17:0] rot_cos;
    logic signed [17:0] rot_sin;
    logic [31:0]        inv_cell_width;
    logic [31:0]        half_mass;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0] new_vel_x;
    logic signed [31:0] new_vel_y;
    logic [47:0]        energy_term;
    logic [47:0]        energy_total;
    logic               sweep_end;
  } res_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_MAP,
    S_CELL,
    S_RD0,
    S_RD1,
    S_INTERP,
    S_GAIN,
    S_HALF,
    S_ADD1,
    S_ROT1,
    S_ROT2,
    S_ROT3,
    S_ROT4,
    S_ROT5,
    S_VEL,
    S_DOTX,
    S_DOTSUM,
    S_ABS,
    S_ELO,
    S_EHI,
    S_TERM,
    S_FIN
  } seq_state_t;

  // Clamps a wide signed value to the 32-bit signed range.
  function automatic logic signed [31:0] sat32(input logic signed [PROD_W-1:0] v);
    logic signed [31:0] r;
    if ((&v[PROD_W-1:31]) || !(|v[PROD_W-1:31])) begin
      r = v[31:0];
    end else if (v[PROD_W-1]) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'sh7FFF_FFFF;
    end
    return r;
  endfunction

  // Clamps a 49-bit unsigned sum to 48 bits.
  function automatic logic [47:0] sat48(input logic [48:0] v);
    logic [47:0] r;
    r = v[48] ? MAX48 : v[47:0];
    return r;
  endfunction

endpackage

// ===== rtl/core/ppp_ram.sv =====
// Generic single-port RAM with registered read data.
module ppp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 129
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata_r <= mem_r[addr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/ppp_mul.sv =====
// Shared signed multiplier with a registered product.
module ppp_mul
  import ppp_pkg::*;
(
  input  logic                     clk,
  input  logic signed [MUL_W-1:0]  a,
  input  logic signed [MUL_W-1:0]  b,
  output logic signed [PROD_W-1:0] p
);

  logic signed [PROD_W-1:0] p_r;

  always_ff @(posedge clk) begin
    p_r <= a * b;
  end

  assign p = p_r;

endmodule

// ===== rtl/core/ppp_seq.sv =====
// Sequencer and datapath registers that step one particle through the shared multiplier.
module ppp_seq
  import ppp_pkg::*;
#(
  parameter int MESH_CELLS = MESH_CELLS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  cfg_t                             cfg,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_mode,
  input  logic [7:0]                       in_mesh_index,
  input  logic [31:0]                      in_position,
  input  logic signed [31:0]               in_vel_x,
  input  logic signed [31:0]               in_vel_y,
  input  logic                             in_last,
  output logic                             ram_we,
  output logic [$clog2(MESH_CELLS+1)-1:0]  ram_addr,
  input  logic signed [31:0]               ram_rdata,
  output logic signed [MUL_W-1:0]          mul_a,
  output logic signed [MUL_W-1:0]          mul_b,
  input  logic signed [PROD_W-1:0]         mul_p,
  input  logic                             out_free,
  output logic                             res_load,
  output res_t                             res
);

  localparam int AW = $clog2(MESH_CELLS + 1);
  localparam logic [AW-1:0] LAST_CELL = AW'(MESH_CELLS - 1);

  seq_state_t state_r, state_nxt;

  logic [31:0]        pos_r;
  logic signed [31:0] vx_r, vy_r;
  logic               last_r;
  logic [AW-1:0]      cell_r;
  logic [16:0]        frac_r;
  logic signed [31:0] e0_r, e_r, h_r, x1_r, y2_r, x2_r, nx_r;
  logic signed [50:0] acc_r;
  logic signed [48:0] dot_r;
  logic [47:0]        dabs_r, lo_r, term_r, sum_r;

  logic [31:0]         idx_ext;
  logic                idx_ok;
  logic [31:0]         cell_hi;
  logic                cell_over;
  logic [AW-1:0]       cell_sel;
  logic [16:0]         frac_sel;
  logic signed [32:0]  diff;
  logic signed [PROD_W-1:0] prod_sh;
  logic signed [50:0]  acc_sh;
  logic signed [32:0]  sum_xh, sum_x2h;
  logic signed [48:0]  dot_neg;
  logic [47:0]         hp;
  logic [47:0]         term_nxt;
  logic [47:0]         total;

  assign idx_ext   = 32'(in_mesh_index);
  assign idx_ok    = idx_ext <= 32'(MESH_CELLS);

  // A position past the last mesh point lands in the last cell with fraction one.
  assign cell_hi   = mul_p[63:32];
  assign cell_over = cell_hi >= 32'(MESH_CELLS);
  assign cell_sel  = cell_over ? LAST_CELL : cell_hi[AW-1:0];
  assign frac_sel  = cell_over ? ONE_Q16 : {1'b0, mul_p[31:16]};

  assign diff    = {ram_rdata[31], ram_rdata} - {e0_r[31], e0_r};
  assign prod_sh = mul_p >>> 16;
  assign acc_sh  = acc_r >>> 16;
  assign sum_xh  = {vx_r[31], vx_r} + {h_r[31], h_r};
  assign sum_x2h = {x2_r[31], x2_r} + {h_r[31], h_r};
  assign dot_neg = -dot_r;
  assign hp      = mul_p[47:0];

  // The high partial product alone already overflows 48 bits when it reaches 2^32.
  always_comb begin
    if (|hp[47:32]) begin
      term_nxt = MAX48;
    end else begin
      term_nxt = sat48({1'b0, lo_r} + {1'b0, hp[31:0], 16'h0000});
    end
  end

  assign total = sat48({1'b0, sum_r} + {1'b0, term_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    ram_we    = 1'b0;
    ram_addr  = cell_r;
    mul_a     = '0;
    mul_b     = '0;
    res_load  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        ram_addr = idx_ext[AW-1:0];
        if (in_valid) begin
          if (in_mode) begin
            state_nxt = S_MAP;
          end else begin
            ram_we = idx_ok;
          end
        end
      end
      S_MAP: begin
        mul_a     = {1'b0, pos_r};
        mul_b     = {1'b0, cfg.inv_cell_width};
        state_nxt = S_CELL;
      end
      S_CELL: begin
        ram_addr  = cell_sel;
        state_nxt = S_RD0;
      end
      S_RD0: begin
        ram_addr  = AW'(cell_r + 1'b1);
        state_nxt = S_RD1;
      end
      S_RD1: begin
        mul_a     = {16'h0000, frac_r};
        mul_b     = diff;
        state_nxt = S_INTERP;
      end
      S_INTERP: begin
        state_nxt = S_GAIN;
      end
      S_GAIN: begin
        mul_a     = {cfg.push_gain[31], cfg.push_gain};
        mul_b     = {e_r[31], e_r};
        state_nxt = S_HALF;
      end
      S_HALF: begin
        state_nxt = S_ADD1;
      end
      S_ADD1: begin
        mul_a     = {vy_r[31], vy_r};
        mul_b     = {{15{cfg.rot_cos[17]}}, cfg.rot_cos};
        state_nxt = S_ROT1;
      end
      S_ROT1: begin
        mul_a     = {x1_r[31], x1_r};
        mul_b     = {{15{cfg.rot_sin[17]}}, cfg.rot_sin};
        state_nxt = S_ROT2;
      end
      S_ROT2: begin
        mul_a     = {x1_r[31], x1_r};
        mul_b     = {{15{cfg.rot_cos[17]}}, cfg.rot_cos};
        state_nxt = S_ROT3;
      end
      S_ROT3: begin
        mul_a     = {vy_r[31], vy_r};
        mul_b     = {{15{cfg.rot_sin[17]}}, cfg.rot_sin};
        state_nxt = S_ROT4;
      end
      S_ROT4: begin
        mul_a     = {y2_r[31], y2_r};
        mul_b     = {vy_r[31], vy_r};
        state_nxt = S_ROT5;
      end
      S_ROT5: begin
        state_nxt = S_VEL;
      end
      S_VEL: begin
        state_nxt = S_DOTX;
      end
      S_DOTX: begin
        mul_a     = {nx_r[31], nx_r};
        mul_b     = {vx_r[31], vx_r};
        state_nxt = S_DOTSUM;
      end
      S_DOTSUM: begin
        state_nxt = S_ABS;
      end
      S_ABS: begin
        state_nxt = S_ELO;
      end
      S_ELO: begin
        mul_a     = {1'b0, cfg.half_mass};
        mul_b     = {1'b0, dabs_r[31:0]};
        state_nxt = S_EHI;
      end
      S_EHI: begin
        mul_a     = {1'b0, cfg.half_mass};
        mul_b     = {17'h0_0000, dabs_r[47:32]};
        state_nxt = S_TERM;
      end
      S_TERM: begin
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          res_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_valid && in_mode) begin
          pos_r  <= in_position;
          vx_r   <= in_vel_x;
          vy_r   <= in_vel_y;
          last_r <= in_last;
        end
      end
      S_CELL: begin
        cell_r <= cell_sel;
        frac_r <= frac_sel;
      end
      S_RD0:    e0_r  <= ram_rdata;
      S_INTERP: e_r   <= e0_r + prod_sh[31:0];
      S_HALF:   h_r   <= sat32(prod_sh);
      S_ADD1:   x1_r  <= sat32(PROD_W'(sum_xh));
      S_ROT1:   acc_r <= mul_p[50:0];
      S_ROT2:   acc_r <= acc_r - mul_p[50:0];
      S_ROT3: begin
        y2_r  <= sat32(PROD_W'(acc_sh));
        acc_r <= mul_p[50:0];
      end
      S_ROT4:   acc_r <= acc_r + mul_p[50:0];
      S_ROT5: begin
        x2_r  <= sat32(PROD_W'(acc_sh));
        dot_r <= prod_sh[48:0];
      end
      S_VEL:    nx_r   <= sat32(PROD_W'(sum_x2h));
      S_DOTSUM: dot_r  <= dot_r + prod_sh[48:0];
      S_ABS:    dabs_r <= dot_r[48] ? dot_neg[47:0] : dot_r[47:0];
      S_EHI:    lo_r   <= mul_p[63:16];
      S_TERM:   term_r <= term_nxt;
      default: begin
      end
    endcase
  end

  // The running energy sum restarts from zero after the last particle of a sweep.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else if (res_load) begin
      sum_r <= last_r ? '0 : total;
    end
  end

  assign res.new_vel_x    = nx_r;
  assign res.new_vel_y    = y2_r;
  assign res.energy_term  = term_r;
  assign res.energy_total = total;
  assign res.sweep_end    = last_r;

endmodule

// ===== rtl/core/pic_particle_push_core.sv =====
// Boris velocity push core for a 1-D electrostatic plasma in signed Q16.16 fixed point.
// A word with in_mode low writes one electric-field value into the field RAM; an index
// beyond MESH_CELLS is dropped, and the RAM holds no defined value until a point is
// written, so every mesh point that particles reach must be loaded first. A word
// with in_mode high pushes one particle: its position is scaled to mesh units, the field is
// interpolated linearly between the two neighboring points, a half push, a rotation by the
// configured cosine and sine and a second half push follow, and one result word carries the
// new velocities, the kinetic-energy term and the saturating running energy sum, which is
// cleared after a particle marked last. A particle occupies the block from acceptance until
// its result is loaded, which waits while the output register is still full; eleven
// products pass one after another through a single shared 33 by 33 multiplier, and the
// two mesh reads go through the single RAM port. in_ready is low while a particle is in
// flight, and the result waits in an output register so that a new word is taken while
// the result is still unclaimed. Configuration words are taken in every cycle and should
// only be written while the block is idle.
module pic_particle_push_core
  import ppp_pkg::*;
#(
  parameter int MESH_CELLS = MESH_CELLS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_mode,
  input  logic [7:0]           in_mesh_index,
  input  logic signed [31:0]   in_field_value,
  input  logic [31:0]          in_position,
  input  logic signed [31:0]   in_vel_x,
  input  logic signed [31:0]   in_vel_y,
  input  logic                 in_last,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [31:0]   out_new_vel_x,
  output logic signed [31:0]   out_new_vel_y,
  output logic [47:0]          out_energy_term,
  output logic [47:0]          out_energy_total,
  output logic                 out_sweep_end
);

  localparam int AW = $clog2(MESH_CELLS + 1);

  cfg_t cfg_r;
  res_t out_res_r;
  logic out_valid_r;

  logic                     ram_we;
  logic [AW-1:0]            ram_addr;
  logic signed [31:0]       ram_rdata;
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] mul_p;
  logic                     out_free;
  logic                     res_load;
  res_t                     res;

  // Configuration registers. Writes to an index past the list are ignored.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.push_gain      <= '0;
      cfg_r.rot_cos        <= 18'sh1_0000;
      cfg_r.rot_sin        <= '0;
      cfg_r.inv_cell_width <= 32'h0001_0000;
      cfg_r.half_mass      <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_PUSH_GAIN: cfg_r.push_gain      <= cfg_data;
        REG_ROT_COS:   cfg_r.rot_cos        <= cfg_data[17:0];
        REG_ROT_SIN:   cfg_r.rot_sin        <= cfg_data[17:0];
        REG_INV_CELL:  cfg_r.inv_cell_width <= cfg_data;
        REG_HALF_MASS: cfg_r.half_mass      <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // The electric-field mesh, one entry per mesh point.
  ppp_ram #(
    .WIDTH (32),
    .DEPTH (MESH_CELLS + 1)
  ) u_field_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (in_field_value),
    .rdata (ram_rdata)
  );

  ppp_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  ppp_seq #(
    .MESH_CELLS (MESH_CELLS)
  ) u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_mode       (in_mode),
    .in_mesh_index (in_mesh_index),
    .in_position   (in_position),
    .in_vel_x      (in_vel_x),
    .in_vel_y      (in_vel_y),
    .in_last       (in_last),
    .ram_we        (ram_we),
    .ram_addr      (ram_addr),
    .ram_rdata     (ram_rdata),
    .mul_a         (mul_a),
    .mul_b         (mul_b),
    .mul_p         (mul_p),
    .out_free      (out_free),
    .res_load      (res_load),
    .res           (res)
  );

  // Output register. It can take a new result in the cycle its old one is claimed.
  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_res_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_new_vel_x    = out_res_r.new_vel_x;
  assign out_new_vel_y    = out_res_r.new_vel_y;
  assign out_energy_term  = out_res_r.energy_term;
  assign out_energy_total = out_res_r.energy_total;
  assign out_sweep_end    = out_res_r.sweep_end;

endmodule

// ===== rtl/core/ppp_checker.sv =====
// Port-level checker of the particle push core and its bind statement.
`include "pic_particle_push_core_assert.svh"

module ppp_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               in_mode,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] out_new_vel_x,
  input logic signed [31:0] out_new_vel_y,
  input logic [47:0]        out_energy_term,
  input logic [47:0]        out_energy_total,
  input logic               out_sweep_end
);

  // A held result word stays valid until it is claimed.
  `PPP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "out_valid dropped")

  // A held result word keeps its payload.
  `PPP_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(out_new_vel_x) && $stable(out_new_vel_y) && $stable(out_energy_term) && $stable(out_energy_total) && $stable(out_sweep_end), "held result changed")

  // The block is busy in the cycle after it takes a particle.
  `PPP_ASSERT_NEXT(a_busy_after_push, clk, rst_n, in_valid && in_ready && in_mode, !in_ready, "ready after particle")

  // The running sum always includes the term it reports.
  `PPP_ASSERT_NOW(a_total_ge_term, clk, rst_n, out_valid, out_energy_total >= out_energy_term, "energy total below term")

endmodule

bind pic_particle_push_core ppp_checker u_ppp_checker (.*);

// ===== tb/sv/ppp_push_scoreboard_pkg.sv =====
// Scoreboard class that predicts and checks the result words of the particle push core.
`timescale 1ns / 100ps
package ppp_push_sb_pkg;
  import ppp_pkg::*;

  localparam int   MESH_POINTS      = MESH_CELLS_DEF + 1;
  localparam logic MODE_FIELD_WRITE = 1'b0;
  localparam logic MODE_PARTICLE    = 1'b1;

  typedef struct packed {
    logic               mode;
    logic [7:0]         mesh_index;
    logic signed [31:0] field_value;
    logic [31:0]        position;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic               last;
  } push_word_t;

  class push_scoreboard;
    longint      gain;
    longint      rot_cos;
    longint      rot_sin;
    logic [31:0] inv_width;
    logic [31:0] half_mass;
    longint      field_mesh [MESH_POINTS];
    bit          mesh_loaded [MESH_POINTS];
    logic [47:0] energy_acc;
    res_t        expected_pushes [$];
    int          error_count;

    function new();
      gain        = 0;
      rot_cos     = ONE_Q16;
      rot_sin     = 0;
      inv_width   = 32'h0001_0000;
      half_mass   = 0;
      energy_acc  = '0;
      error_count = 0;
      foreach (mesh_loaded[k]) begin
        mesh_loaded[k] = 1'b0;
        field_mesh[k]  = 0;
      end
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
      case (idx)
        REG_PUSH_GAIN: gain      = longint'($signed(data));
        REG_ROT_COS:   rot_cos   = longint'($signed(data[17:0]));
        REG_ROT_SIN:   rot_sin   = longint'($signed(data[17:0]));
        REG_INV_CELL:  inv_width = data;
        REG_HALF_MASS: half_mass = data;
        default: ;
      endcase
    endfunction

    // Maps a position to its mesh cell and Q0.16 fraction, clamping past the mesh end.
    function void locate(logic [31:0] pos, output int mesh_cell, output longint frac);
      logic [63:0] coord;
      coord = {32'b0, pos} * {32'b0, inv_width};
      if (coord[63:32] >= MESH_CELLS_DEF) begin
        mesh_cell = MESH_CELLS_DEF - 1;
        frac      = ONE_Q16;
      end else begin
        mesh_cell = int'(coord[63:32]);
        frac      = longint'(coord[31:16]);
      end
    endfunction

    function longint clamp32(longint v);
      if (v > 64'sh7FFF_FFFF) return 64'sh7FFF_FFFF;
      if (v < -64'sh8000_0000) return -64'sh8000_0000;
      return v;
    endfunction

    function res_t boris_push(push_word_t w);
      int              mesh_cell;
      longint          frac, vx, vy, e, h, x1, x2, y2, nx, ny, dotv;
      longint unsigned dot_mag;
      logic [95:0]     prod;
      logic [47:0]     term;
      logic [48:0]     acc_sum;
      res_t            r;
      locate(w.position, mesh_cell, frac);
      vx = longint'($signed(w.vel_x));
      vy = longint'($signed(w.vel_y));
      e  = (frac * field_mesh[mesh_cell + 1] + (65536 - frac) * field_mesh[mesh_cell]) >>> 16;
      h  = clamp32((gain * e) >>> 16);
      x1 = clamp32(vx + h);
      x2 = clamp32((x1 * rot_cos + vy * rot_sin) >>> 16);
      y2 = clamp32((vy * rot_cos - x1 * rot_sin) >>> 16);
      nx = clamp32(x2 + h);
      ny = y2;
      dotv    = ((nx * vx) >>> 16) + ((ny * vy) >>> 16);
      dot_mag = (dotv < 0) ? -dotv : dotv;
      prod    = (96'(half_mass) * 96'(dot_mag)) >> 16;
      term    = (|prod[95:48]) ? MAX48 : prod[47:0];
      acc_sum = {1'b0, energy_acc} + {1'b0, term};
      r.new_vel_x    = 32'(nx);
      r.new_vel_y    = 32'(ny);
      r.energy_term  = term;
      r.energy_total = acc_sum[48] ? MAX48 : acc_sum[47:0];
      r.sweep_end    = w.last;
      energy_acc     = w.last ? '0 : r.energy_total;
      return r;
    endfunction

    function void accept_word(push_word_t w);
      if (w.mode == MODE_FIELD_WRITE) begin
        if (w.mesh_index <= MESH_CELLS_DEF) begin
          field_mesh[w.mesh_index]  = longint'($signed(w.field_value));
          mesh_loaded[w.mesh_index] = 1'b1;
        end
      end else begin
        expected_pushes.push_back(boris_push(w));
      end
    endfunction

    function int pending_count();
      return expected_pushes.size();
    endfunction

    function void check_push_result(res_t got);
      res_t want;
      if (expected_pushes.size() == 0) begin
        $error("result word with no particle outstanding: new_vel_x %0d", got.new_vel_x);
        error_count++;
        return;
      end
      want = expected_pushes.pop_front();
      if (got.new_vel_x !== want.new_vel_x) begin
        $error("new_vel_x expected %0d actual %0d", want.new_vel_x, got.new_vel_x);
        error_count++;
      end
      if (got.new_vel_y !== want.new_vel_y) begin
        $error("new_vel_y expected %0d actual %0d", want.new_vel_y, got.new_vel_y);
        error_count++;
      end
      if (got.energy_term !== want.energy_term) begin
        $error("energy_term expected %0d actual %0d", want.energy_term, got.energy_term);
        error_count++;
      end
      if (got.energy_total !== want.energy_total) begin
        $error("energy_total expected %0d actual %0d", want.energy_total, got.energy_total);
        error_count++;
      end
      if (got.sweep_end !== want.sweep_end) begin
        $error("sweep_end expected %0d actual %0d", want.sweep_end, got.sweep_end);
        error_count++;
      end
    endfunction
  endclass

endpackage

// ===== tb/sv/tb_top.sv =====
// Top-level testbench of the particle push core: stimulus, handshakes, checking and watchdog.
`timescale 1ns / 100ps
module tb_top;
  import ppp_pkg::*;
  import ppp_push_sb_pkg::*;

  // A particle keeps the core busy until its result is loaded, so the settle time after the
  // last result covers a field write or particle that is still in flight.
  localparam int RESET_CYCLES   = 6;
  localparam int SETTLE_CYCLES  = 40;
  localparam int HOLD_CYCLES    = 160;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASES         = 8;
  localparam int PHASE_WORDS    = 64;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0]          cfg_data;
  logic                 in_valid;
  logic                 in_ready;
  logic                 in_mode;
  logic [7:0]           in_mesh_index;
  logic signed [31:0]   in_field_value;
  logic [31:0]          in_position;
  logic signed [31:0]   in_vel_x;
  logic signed [31:0]   in_vel_y;
  logic                 in_last;
  logic                 out_valid;
  logic                 out_ready;
  logic signed [31:0]   out_new_vel_x;
  logic signed [31:0]   out_new_vel_y;
  logic [47:0]          out_energy_term;
  logic [47:0]          out_energy_total;
  logic                 out_sweep_end;

  push_scoreboard push_sb = new();

  // Random idling on both channels is enabled per phase; the sender asks the
  // receiver for one long hold-off through hold_request.
  bit idling_on    = 1'b1;
  bit hold_request = 1'b0;
  int quiet_cycles = 0;

  pic_particle_push_core u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_mode          (in_mode),
    .in_mesh_index    (in_mesh_index),
    .in_field_value   (in_field_value),
    .in_position      (in_position),
    .in_vel_x         (in_vel_x),
    .in_vel_y         (in_vel_y),
    .in_last          (in_last),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_new_vel_x    (out_new_vel_x),
    .out_new_vel_y    (out_new_vel_y),
    .out_energy_term  (out_energy_term),
    .out_energy_total (out_energy_total),
    .out_sweep_end    (out_sweep_end)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Result words are sampled at the edge where they are taken, before any
  // nonblocking update of that edge lands.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      push_sb.check_push_result({out_new_vel_x, out_new_vel_y, out_energy_term,
                                 out_energy_total, out_sweep_end});
    end
  end

  // The watchdog restarts whenever any channel moves a word. A stuck core or a
  // result that never arrives ends the run here.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $error("no word moved on any channel for %0d cycles", WATCHDOG_LIMIT);
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver: one assignment of out_ready per loop pass, then time advances.
  // A hold request keeps out_ready low long enough for the output register and
  // the particle behind it to fill, so that in_ready drops.
  initial begin
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Mostly moderate Q16.16 values so that results are not all saturated, with
  // the extremes and full-range values mixed in.
  function automatic logic signed [31:0] rand_q16();
    case ($urandom_range(0, 9))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2, 3:    return $urandom;
      default: return int'($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
    endcase
  endfunction

  // Fields that the mode does not use carry random bits.
  function automatic push_word_t field_word(logic [7:0] idx, logic signed [31:0] value,
                                            logic last);
    push_word_t w;
    w.mode        = MODE_FIELD_WRITE;
    w.mesh_index  = idx;
    w.field_value = value;
    w.position    = $urandom;
    w.vel_x       = $urandom;
    w.vel_y       = $urandom;
    w.last        = last;
    return w;
  endfunction

  function automatic push_word_t particle_word(logic [31:0] pos, logic signed [31:0] vx,
                                               logic signed [31:0] vy, logic last);
    push_word_t w;
    w.mode        = MODE_PARTICLE;
    w.mesh_index  = 8'($urandom);
    w.field_value = $urandom;
    w.position    = pos;
    w.vel_x       = vx;
    w.vel_y       = vy;
    w.last        = last;
    return w;
  endfunction

  // Field writes occasionally aim past the mesh, where the core drops them.
  function automatic push_word_t random_field_word();
    logic [7:0] idx;
    idx = ($urandom_range(0, 11) == 0) ? 8'($urandom_range(MESH_POINTS, 255))
                                       : 8'($urandom_range(0, MESH_CELLS_DEF));
    return field_word(idx, rand_q16(), 1'($urandom_range(0, 1)));
  endfunction

  // Sweeps end on a particle marked last about once in twelve particles.
  function automatic push_word_t random_particle();
    logic [31:0] pos;
    pos = ($urandom_range(0, 2) == 0) ? $urandom : $urandom_range(0, 32'h0080_0000);
    return particle_word(pos, rand_q16(), rand_q16(), $urandom_range(0, 11) == 0);
  endfunction

  function automatic cfg_t random_config();
    cfg_t c;
    c.push_gain = ($urandom_range(0, 3) == 0) ? $urandom
                                              : int'($urandom_range(0, 262144)) - 131072;
    c.rot_cos   = 18'(int'($urandom_range(0, 131072)) - 65536);
    c.rot_sin   = 18'(int'($urandom_range(0, 131072)) - 65536);
    case ($urandom_range(0, 3))
      0:       c.inv_cell_width = 32'h0001_0000;
      1:       c.inv_cell_width = 32'h0000_4000;
      2:       c.inv_cell_width = 32'h0008_0000;
      default: c.inv_cell_width = $urandom;
    endcase
    c.half_mass = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32'h0004_0000);
    return c;
  endfunction

  // Offers one input word and returns at the edge where it is taken. in_valid
  // is only lowered for a random gap, never between back-to-back words.
  task automatic send_word(input push_word_t w);
    if (idling_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_mode        <= w.mode;
    in_mesh_index  <= w.mesh_index;
    in_field_value <= w.field_value;
    in_position    <= w.position;
    in_vel_x       <= w.vel_x;
    in_vel_y       <= w.vel_y;
    in_last        <= w.last;
    do @(posedge clk); while (!in_ready);
    push_sb.accept_word(w);
  endtask

  // The field RAM holds nothing defined until written, so both mesh points a
  // particle interpolates between are loaded before the particle goes in.
  task automatic send_particle(input push_word_t w);
    int     mesh_cell;
    longint frac;
    push_sb.locate(w.position, mesh_cell, frac);
    for (int k = mesh_cell; k <= mesh_cell + 1; k++) begin
      if (!push_sb.mesh_loaded[k]) send_word(field_word(8'(k), rand_q16(), 1'b0));
    end
    send_word(w);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    push_sb.write_register(idx, data);
  endtask

  // Writes every register, then the unused indexes, which must change nothing.
  task automatic program_registers(input cfg_t c);
    write_reg(REG_PUSH_GAIN, c.push_gain);
    write_reg(REG_ROT_COS, {{14{c.rot_cos[17]}}, c.rot_cos});
    write_reg(REG_ROT_SIN, {{14{c.rot_sin[17]}}, c.rot_sin});
    write_reg(REG_INV_CELL, c.inv_cell_width);
    write_reg(REG_HALF_MASS, c.half_mass);
    for (int k = int'(REG_HALF_MASS) + 1; k < (1 << CFG_IDX_W); k++) begin
      write_reg(CFG_IDX_W'(k), $urandom);
    end
    cfg_valid <= 1'b0;
  endtask

  // Registers change only with the core idle: every result in, then enough
  // cycles for a trailing field write to retire.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (push_sb.pending_count() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    cfg_t c;
    rst_n          <= 1'b0;
    cfg_valid      <= 1'b0;
    cfg_index      <= '0;
    cfg_data       <= '0;
    in_valid       <= 1'b0;
    in_mode        <= MODE_FIELD_WRITE;
    in_mesh_index  <= '0;
    in_field_value <= '0;
    in_position    <= '0;
    in_vel_x       <= '0;
    in_vel_y       <= '0;
    in_last        <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: a plain rotation with a modest push and mass.
    c = '{push_gain: 32'sh0000_C000, rot_cos: 18'sd52000, rot_sin: -18'sd39000,
          inv_cell_width: 32'h0001_0000, half_mass: 32'h0000_8000};
    program_registers(c);

    // Extreme field values at the mesh start; a last flag on a field write must
    // be ignored, and writes past the mesh end must be dropped.
    send_word(field_word(8'd0, 32'sh7FFF_FFFF, 1'b0));
    send_word(field_word(8'd1, 32'sh8000_0000, 1'b0));
    send_word(field_word(8'd2, 32'sh0000_0000, 1'b0));
    send_word(field_word(8'd127, 32'sh0001_0000, 1'b0));
    send_word(field_word(8'd128, 32'shFFFF_0000, 1'b1));
    send_word(field_word(8'd129, 32'sh1234_5678, 1'b0));
    send_word(field_word(8'd255, 32'shFFFF_FFFF, 1'b1));

    // Particles at the mesh start, mid-cell, the top fraction of a cell, the
    // last cell, exactly at the mesh end and far past it. The two particles
    // marked last close one sweep and then a sweep of a single particle.
    send_particle(particle_word(32'h0000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 1'b0));
    send_particle(particle_word(32'h0000_8000, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0));
    send_particle(particle_word(32'h0001_FFFF, 32'sh0003_0000, -32'sh0002_0000, 1'b0));
    send_particle(particle_word(32'h007F_FFFF, 32'sh0000_0000, 32'sh0000_0000, 1'b0));
    send_particle(particle_word(32'h0080_0000, -32'sh0001_8000, 32'sh0004_0000, 1'b0));
    send_particle(particle_word(32'hFFFF_FFFF, -32'sh0000_0001, 32'sh0000_0001, 1'b1));
    send_particle(particle_word(32'h0000_0000, 32'sh0000_0000, 32'sh0000_0000, 1'b1));

    // Load the whole mesh so that the random particles rarely need extra writes.
    for (int k = 0; k < MESH_POINTS; k++) begin
      send_word(field_word(8'(k), rand_q16(), 1'($urandom_range(0, 1))));
    end

    // Random phases. The first two take the register extremes; phase 2 starts
    // with the long receiver hold-off, phase 4 pauses the sender halfway until
    // the core has handed over every result, and phase 5 and the closing phase
    // run without idling.
    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      case (p)
        0: c = '{push_gain: 32'sh7FFF_FFFF, rot_cos: 18'sd65536, rot_sin: 18'sd65536,
                 inv_cell_width: 32'hFFFF_FFFF, half_mass: 32'hFFFF_FFFF};
        1: c = '{push_gain: 32'sh8000_0000, rot_cos: -18'sd65536, rot_sin: -18'sd65536,
                 inv_cell_width: 32'h0000_0000, half_mass: 32'h0000_0000};
        default: c = random_config();
      endcase
      program_registers(c);
      idling_on = !(p == 5 || p == PHASES - 1);
      if (p == 2) hold_request = 1'b1;
      for (int k = 0; k < PHASE_WORDS; k++) begin
        if (p == 4 && k == PHASE_WORDS / 2) begin
          in_valid <= 1'b0;
          @(posedge clk);
          while (push_sb.pending_count() != 0) @(posedge clk);
        end
        if ($urandom_range(0, 6) == 0) begin
          send_word(random_field_word());
        end else begin
          send_particle(random_particle());
        end
      end
    end

    // Let the last results drain, then watch a little longer for strays.
    in_valid <= 1'b0;
    while (push_sb.pending_count() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (push_sb.error_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
